// ===== hdl/prhs_pkg.sv =====
// ---------------------------------------------------------------------------
// prhs_pkg
// Types, codes and helpers shared by the pointer record heap sorter.
// ---------------------------------------------------------------------------
package prhs_pkg;

    localparam int KEY_W   = 48;
    localparam int COUNT_W = 11;

    // action codes carried by an input beat
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_SORT  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // status codes carried by a result beat
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // one stored record; target sits on top so a plain compare orders it
    typedef struct packed {
        logic [KEY_W-1:0] target;
        logic [KEY_W-1:0] location;
    } t_rec;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] target_value;
        logic [KEY_W-1:0] location;
    } t_in_beat;

    typedef struct packed {
        logic [KEY_W-1:0]   target_value_res;
        logic [KEY_W-1:0]   location_res;
        logic [COUNT_W-1:0] record_count;
        logic               last;
        logic [1:0]         status;
    } t_out_beat;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_BLD_RD,
        S_BLD_V,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_CMP,
        S_NEXT,
        S_EXT_RD0,
        S_EXT_RD1,
        S_EXT_WR,
        S_DONE
    } t_state;

    // true when record a orders after record b
    function automatic logic rec_after(input t_rec a, input t_rec b);
        return {a.target, a.location} > {b.target, b.location};
    endfunction

endpackage

// ===== hdl/prhs_if.sv =====
// ---------------------------------------------------------------------------
// prhs_in_if / prhs_out_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface prhs_in_if;
    import prhs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface prhs_out_if;
    import prhs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/pointer_record_heap_sorter.sv =====
// ---------------------------------------------------------------------------
// pointer_record_heap_sorter
// Record store with load, in-place max-heap sort, ordered read-out and clear.
// ---------------------------------------------------------------------------
//
//   channel  dir  beat contents
//   -------  ---  ---------------------------------------------------------
//   i_in     in   action, target_value, location
//   o_out    out  target_value_res, location_res, record_count, last, status
//
// Load, clear and a read past the end are answered from S_IDLE; a read goes
// through S_READ (registered RAM read), a sort of at most one record through
// S_DONE. A sort holds i_in.ready low for about (3 * n / 2) sift passes,
// each stepping S_SIFT_L, S_SIFT_R, S_SIFT_CMP per heap level, plus setup
// and wrap-up states, all bounded by the single RAM read port. Reset clears
// every control register but no payload register; RAM contents are never
// read before a load writes them. A stalled o_out holds the result register
// and i_in.ready stays low until the beat leaves.
// ---------------------------------------------------------------------------
module pointer_record_heap_sorter #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    prhs_in_if.sink           i_in,
    prhs_out_if.source        o_out
);
    import prhs_pkg::*;

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int IW     = CNT_W + 1;
    localparam int REC_W  = $bits(t_rec);

    // control registers
    t_state           r_state,  n_state;
    logic [CNT_W-1:0] r_total,  n_total;
    logic [CNT_W-1:0] r_rp,     n_rp;
    logic [CNT_W-1:0] r_k,      n_k;
    logic [CNT_W-1:0] r_n,      n_n;
    logic [AW-1:0]    r_node,   n_node;
    logic             r_build,  n_build;
    logic             r_lc_gt,  n_lc_gt;
    logic             r_has_rc, n_has_rc;
    logic             r_out_valid, n_out_valid;

    // payload registers
    t_rec             r_v,   n_v;
    t_rec             r_lc,  n_lc;
    t_out_beat        r_out, n_out;

    // RAM port signals
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_rec             ram_wdata;
    logic [AW-1:0]    ram_raddr;
    t_rec             ram_rdata;

    logic             in_acc;
    logic [IW-1:0]    lc_idx;
    logic [IW-1:0]    rc_idx;
    logic [CNT_W-1:0] k_dec;
    t_rec             big_rec;
    logic             rc_gt;

    prhs_ram #(
        .WIDTH (REC_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake
    assign i_in.ready    = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc        = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // heap index arithmetic
    assign lc_idx = IW'({r_node, 1'b1});
    assign rc_idx = lc_idx + IW'(1);
    assign k_dec  = r_k - CNT_W'(1);

    // larger of the sifted record and its left child, then right child test
    assign big_rec = r_lc_gt ? r_lc : r_v;
    assign rc_gt   = r_has_rc && rec_after(ram_rdata, big_rec);

    // next state, RAM control and result beat
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_rp        = r_rp;
        n_k         = r_k;
        n_n         = r_n;
        n_node      = r_node;
        n_build     = r_build;
        n_lc_gt     = r_lc_gt;
        n_has_rc    = r_has_rc;
        n_v         = r_v;
        n_lc        = r_lc;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = r_v;
        ram_raddr   = r_node;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out                  = '0;
                    n_out.record_count     = COUNT_W'(r_total);
                    n_out.status           = STAT_OK;
                    unique case (i_in.payload.action)
                        ACT_LOAD: begin
                            n_out_valid = 1'b1;
                            if (r_total < CNT_W'(STORE_DEPTH)) begin
                                ram_we             = 1'b1;
                                ram_waddr          = r_total[AW-1:0];
                                ram_wdata.target   = i_in.payload.target_value;
                                ram_wdata.location = i_in.payload.location;
                                n_total            = r_total + CNT_W'(1);
                                n_out.record_count = COUNT_W'(n_total);
                            end else begin
                                n_out.status = STAT_FULL;
                            end
                        end
                        ACT_SORT: begin
                            n_rp = '0;
                            if (r_total <= CNT_W'(1)) begin
                                n_state = S_DONE;
                            end else begin
                                n_n     = r_total;
                                n_k     = r_total >> 1;
                                n_build = 1'b1;
                                n_state = S_BLD_RD;
                            end
                        end
                        ACT_READ: begin
                            if (r_rp < r_total) begin
                                ram_raddr = r_rp[AW-1:0];
                                n_rp      = r_rp + CNT_W'(1);
                                n_state   = S_READ;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out.status = STAT_EMPTY;
                            end
                        end
                        ACT_CLEAR: begin
                            n_out_valid        = 1'b1;
                            n_total            = '0;
                            n_rp               = '0;
                            n_out.record_count = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // read data is back; the output register is known to be free
            S_READ: begin
                n_out_valid            = 1'b1;
                n_out.target_value_res = ram_rdata.target;
                n_out.location_res     = ram_rdata.location;
                n_out.last             = (r_rp == r_total);
                n_state                = S_IDLE;
            end

            // heap build: fetch node k-1 as the record to sift
            S_BLD_RD: begin
                ram_raddr = k_dec[AW-1:0];
                n_node    = k_dec[AW-1:0];
                n_state   = S_BLD_V;
            end

            S_BLD_V: begin
                n_v     = ram_rdata;
                n_state = S_SIFT_L;
            end

            // sift: leaf check (a leaf settles the record), else fetch left child
            S_SIFT_L: begin
                if (lc_idx < IW'(r_n)) begin
                    ram_raddr = lc_idx[AW-1:0];
                    n_state   = S_SIFT_R;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = r_v;
                    n_state   = S_NEXT;
                end
            end

            // left child arrives; fetch right child if present
            S_SIFT_R: begin
                n_lc     = ram_rdata;
                n_lc_gt  = rec_after(ram_rdata, r_v);
                n_has_rc = rc_idx < IW'(r_n);
                ram_raddr = rc_idx[AW-1:0];
                n_state  = S_SIFT_CMP;
            end

            // move the larger child up into the hole, or settle the record
            S_SIFT_CMP: begin
                ram_we = 1'b1;
                if (rc_gt) begin
                    ram_wdata = ram_rdata;
                    n_node    = rc_idx[AW-1:0];
                    n_state   = S_SIFT_L;
                end else if (r_lc_gt) begin
                    ram_wdata = r_lc;
                    n_node    = lc_idx[AW-1:0];
                    n_state   = S_SIFT_L;
                end else begin
                    ram_wdata = r_v;
                    n_state   = S_NEXT;
                end
            end

            // step the build or extract loop
            S_NEXT: begin
                if (r_k == CNT_W'(1)) begin
                    if (r_build) begin
                        n_build = 1'b0;
                        n_k     = r_n - CNT_W'(1);
                        n_state = S_EXT_RD0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_k     = k_dec;
                    n_state = r_build ? S_BLD_RD : S_EXT_RD0;
                end
            end

            // extract: take element k as the record to sift from the root
            S_EXT_RD0: begin
                ram_raddr = r_k[AW-1:0];
                n_state   = S_EXT_RD1;
            end

            S_EXT_RD1: begin
                n_v       = ram_rdata;
                ram_raddr = '0;
                n_state   = S_EXT_WR;
            end

            // old root goes to slot k; heap shrinks to k
            S_EXT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = ram_rdata;
                n_n       = r_k;
                n_node    = '0;
                n_state   = S_SIFT_L;
            end

            S_DONE: begin
                n_out_valid        = 1'b1;
                n_out              = '0;
                n_out.record_count = COUNT_W'(r_total);
                n_out.status       = STAT_OK;
                n_state            = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_rp        <= '0;
            r_k         <= '0;
            r_n         <= '0;
            r_node      <= '0;
            r_build     <= 1'b0;
            r_lc_gt     <= 1'b0;
            r_has_rc    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_rp        <= n_rp;
            r_k         <= n_k;
            r_n         <= n_n;
            r_node      <= n_node;
            r_build     <= n_build;
            r_lc_gt     <= n_lc_gt;
            r_has_rc    <= n_has_rc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_lc  <= n_lc;
        r_out <= n_out;
    end

endmodule

// ===== hdl/prhs_ram.sv =====
// ---------------------------------------------------------------------------
// prhs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module prhs_ram #(
    parameter int  WIDTH = 96,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
